// File: rtl/core/smrc_pkg.sv
package smrc_pkg;

  typedef enum logic [7:0] {
    OP_INC  = 8'h01,
    OP_DEC  = 8'h02,
    OP_MOV  = 8'h03,
    OP_MOVC = 8'h04,
    OP_LSL  = 8'h05,
    OP_LSR  = 8'h06,
    OP_JMP  = 8'h07,
    OP_JZ   = 8'h08,
    OP_JNZ  = 8'h09,
    OP_JFE  = 8'h0A,
    OP_RET  = 8'h0B,
    OP_ADD  = 8'h0C,
    OP_SUB  = 8'h0D,
    OP_XOR  = 8'h0E,
    OP_OR   = 8'h0F,
    OP_IN   = 8'h10,
    OP_OUT  = 8'h11
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_HALT    = 2'd1,
    ST_ILLEGAL = 2'd2
  } exec_status_t;

  localparam logic [7:0] PC_STEP = 8'd2;
  localparam logic [3:0] R0_IDX  = 4'd0;

  // architectural state besides the register file
  typedef struct packed {
    logic [7:0] pc;
    logic       zero;
    logic       end_f;
    logic       halted;
  } arch_state_t;

  // register file write request
  typedef struct packed {
    logic       en;
    logic [3:0] idx;
    logic [7:0] data;
  } rf_wr_t;

  typedef struct packed {
    logic [7:0]   next_pc;
    exec_status_t status;
    logic         ovalid;
    logic [7:0]   ochar;
    logic         zero;
    logic         end_f;
  } exec_res_t;

endpackage

// File: rtl/core/smrc_regfile.sv
module smrc_regfile
  import smrc_pkg::*;
#(
  parameter int REG_COUNT = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       rd_en,
  input  logic [3:0] rd_a_idx,
  input  logic [3:0] rd_b_idx,
  input  rf_wr_t     wr,
  output logic [7:0] rd_a_r,
  output logic [7:0] rd_b_r
);

  localparam int IDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

  logic [7:0]           mem [REG_COUNT];
  logic [REG_COUNT-1:0] vld_r;
  logic                 wr_ok;
  logic [7:0]           rd_a_nxt;
  logic [7:0]           rd_b_nxt;

  // writes beyond the implemented registers are dropped
  assign wr_ok = wr.en && (int'(wr.idx) < REG_COUNT);

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[wr.idx[IDX_W-1:0]] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr_ok) begin
      vld_r[wr.idx[IDX_W-1:0]] <= 1'b1;
    end
  end

  // write-first: a read in the cycle of a write to the same entry sees the new data
  always_comb begin
    rd_a_nxt = 8'd0;
    rd_b_nxt = 8'd0;
    if (int'(rd_a_idx) < REG_COUNT) begin
      if (wr_ok && (wr.idx == rd_a_idx)) begin
        rd_a_nxt = wr.data;
      end else if (vld_r[rd_a_idx[IDX_W-1:0]]) begin
        rd_a_nxt = mem[rd_a_idx[IDX_W-1:0]];
      end
    end
    if (int'(rd_b_idx) < REG_COUNT) begin
      if (wr_ok && (wr.idx == rd_b_idx)) begin
        rd_b_nxt = wr.data;
      end else if (vld_r[rd_b_idx[IDX_W-1:0]]) begin
        rd_b_nxt = mem[rd_b_idx[IDX_W-1:0]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_a_r <= rd_a_nxt;
      rd_b_r <= rd_b_nxt;
    end
  end

endmodule

// File: rtl/core/smrc_exec.sv
module smrc_exec
  import smrc_pkg::*;
(
  input  logic [7:0]  op,
  input  logic [7:0]  arg,
  input  logic [7:0]  ch,
  input  logic        at_end,
  input  logic [7:0]  opa,
  input  logic [7:0]  opb,
  input  arch_state_t st,
  output arch_state_t st_nxt,
  output rf_wr_t      wr,
  output exec_res_t   res
);

  logic [7:0]   alu_res;
  logic         alu;
  logic         take;
  exec_status_t status;
  logic         ovalid;
  logic [7:0]   ochar;

  always_comb begin
    alu_res = 8'd0;
    alu     = 1'b0;
    take    = 1'b0;
    status  = ST_OK;
    ovalid  = 1'b0;
    ochar   = 8'd0;
    st_nxt  = st;
    wr      = '0;

    if (st.halted) begin
      status = ST_HALT;
    end else begin
      unique case (op)
        OP_INC:  begin alu_res = opa + 8'd1; alu = 1'b1; end
        OP_DEC:  begin alu_res = opa - 8'd1; alu = 1'b1; end
        OP_MOV:  begin alu_res = opb;        alu = 1'b1; end
        OP_MOVC: wr = '{en: 1'b1, idx: R0_IDX, data: arg};
        OP_LSL:  begin alu_res = {opa[6:0], 1'b0}; alu = 1'b1; end
        OP_LSR:  begin alu_res = {1'b0, opa[7:1]}; alu = 1'b1; end
        OP_JMP:  take = 1'b1;
        OP_JZ:   take = st.zero;
        OP_JNZ:  take = !st.zero;
        OP_JFE:  take = st.end_f;
        OP_RET:  begin
          st_nxt.halted = 1'b1;
          status        = ST_HALT;
        end
        OP_ADD:  begin alu_res = opa + opb; alu = 1'b1; end
        OP_SUB:  begin alu_res = opa - opb; alu = 1'b1; end
        OP_XOR:  begin alu_res = opa ^ opb; alu = 1'b1; end
        OP_OR:   begin alu_res = opa | opb; alu = 1'b1; end
        OP_IN:   begin
          if (at_end) begin
            st_nxt.end_f = 1'b1;
          end else begin
            wr = '{en: 1'b1, idx: arg[3:0], data: ch};
          end
        end
        OP_OUT:  begin ovalid = 1'b1; ochar = opa; end
        default: status = ST_ILLEGAL;
      endcase

      if (alu) begin
        wr          = '{en: 1'b1, idx: arg[3:0], data: alu_res};
        st_nxt.zero = (alu_res == 8'd0);
      end

      // jump offset is signed, but an 8-bit wrapping add gives the same counter
      if (status == ST_OK) begin
        st_nxt.pc = take ? (st.pc + arg) : (st.pc + PC_STEP);
      end
    end

    res.next_pc = st_nxt.pc;
    res.status  = status;
    res.ovalid  = ovalid;
    res.ochar   = ochar;
    res.zero    = st_nxt.zero;
    res.end_f   = st_nxt.end_f;
  end

endmodule

// File: rtl/core/small_register_cpu_execute_core.sv
// Execute core for a small 8-bit machine: each input transaction carries one
// two-byte instruction (opcode and operand byte) plus the text byte and
// end-of-input mark used by IN, and yields one result transaction with the
// next program counter, status (executed, halted, illegal opcode), any OUT
// character and the zero and end-of-input flags. The 16-entry register file,
// counter and flags live inside and are cleared by reset. Operands are read
// from the register file as the instruction is taken into the input register,
// with the write of the instruction executing in that cycle forwarded; once the
// result register is free, the ALU and branch logic update all state and load
// the result register. One instruction is taken per cycle as long as results
// are being drained.
module small_register_cpu_execute_core
  import smrc_pkg::*;
#(
  parameter int REG_COUNT = 16
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_op_code,
  input  logic [7:0] in_operand_byte,
  input  logic [7:0] in_input_char,
  input  logic       in_input_at_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_next_pc,
  output logic [1:0] out_exec_status,
  output logic       out_out_valid,
  output logic [7:0] out_out_char,
  output logic       out_zero_now,
  output logic       out_end_seen
);

  logic        in_vld_r;
  logic [7:0]  op_r;
  logic [7:0]  arg_r;
  logic [7:0]  ch_r;
  logic        at_end_r;
  logic        in_acc;
  logic        exec_fire;

  logic [7:0]  opa;
  logic [7:0]  opb;

  arch_state_t st_r;
  arch_state_t st_nxt;
  rf_wr_t      exec_wr;
  rf_wr_t      rf_wr;
  exec_res_t   exec_res;

  logic        out_vld_r;
  exec_res_t   res_r;

  assign exec_fire = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready  = !in_vld_r || exec_fire;
  assign in_acc    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r     <= in_op_code;
      arg_r    <= in_operand_byte;
      ch_r     <= in_input_char;
      at_end_r <= in_input_at_end;
    end
  end

  always_comb begin
    rf_wr    = exec_wr;
    rf_wr.en = exec_wr.en && exec_fire;
  end

  smrc_regfile #(
    .REG_COUNT(REG_COUNT)
  ) u_regfile (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (in_acc),
    .rd_a_idx (in_operand_byte[3:0]),
    .rd_b_idx (in_operand_byte[7:4]),
    .wr       (rf_wr),
    .rd_a_r   (opa),
    .rd_b_r   (opb)
  );

  smrc_exec u_exec (
    .op     (op_r),
    .arg    (arg_r),
    .ch     (ch_r),
    .at_end (at_end_r),
    .opa    (opa),
    .opb    (opb),
    .st     (st_r),
    .st_nxt (st_nxt),
    .wr     (exec_wr),
    .res    (exec_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (exec_fire) begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (exec_fire) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) begin
      res_r <= exec_res;
    end
  end

  assign out_valid       = out_vld_r;
  assign out_next_pc     = res_r.next_pc;
  assign out_exec_status = res_r.status;
  assign out_out_valid   = res_r.ovalid;
  assign out_out_char    = res_r.ochar;
  assign out_zero_now    = res_r.zero;
  assign out_end_seen    = res_r.end_f;

  a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
    !out_vld_r |-> in_ready)
    else $error("input stalled with empty result register");

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.halted |=> st_r.halted)
    else $error("halted flag cleared");

  a_halted_pc_held: assert property (@(posedge clk) disable iff (!rst_n)
    exec_fire && st_r.halted |=> $stable(st_r.pc))
    else $error("counter moved while halted");

  a_result_pc_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_next_pc == st_r.pc))
    else $error("reported counter differs from state");

endmodule

// File: tb/sv/small_register_cpu_execute_core_tb.sv
`timescale 1ns / 1ps

module small_register_cpu_execute_core_tb;
  import smrc_pkg::*;

  localparam int RANDOM_ITEMS = 2000;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_GAP      = 16;
  localparam int HEAD_ROWS    = 23;

  // opcodes outside the legal range
  localparam logic [7:0] ILL_LOW   = 8'h00;
  localparam logic [7:0] ILL_FIRST = 8'h12;
  localparam logic [7:0] ILL_HIGH  = 8'hFF;

  typedef struct packed {
    logic [7:0] op;
    logic [7:0] arg;
    logic [7:0] ch;
    logic       at_end;
    logic       known;
    exec_res_t  res;
  } instr_row_t;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_op_code;
  logic [7:0] in_operand_byte;
  logic [7:0] in_input_char;
  logic       in_input_at_end;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_next_pc;
  logic [1:0] out_exec_status;
  logic       out_out_valid;
  logic [7:0] out_out_char;
  logic       out_zero_now;
  logic       out_end_seen;

  // machine state mirror
  logic [7:0] regs_mirror [16];
  logic [7:0] pc_mirror;
  logic       zero_mirror;
  logic       end_mirror;
  logic       halt_mirror;

  exec_res_t  pending_results [$];
  instr_row_t instr_rows [$];
  int         err_count = 0;
  int         cycle_count = 0;
  bit         calm = 1'b0;

  // every legal opcode but RET, so the random part never halts the machine
  opcode_t    run_ops [16] = '{OP_INC, OP_DEC, OP_MOV, OP_MOVC, OP_LSL, OP_LSR,
                               OP_JMP, OP_JZ, OP_JNZ, OP_JFE, OP_ADD, OP_SUB,
                               OP_XOR, OP_OR, OP_IN, OP_OUT};

  small_register_cpu_execute_core dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op_code      (in_op_code),
    .in_operand_byte (in_operand_byte),
    .in_input_char   (in_input_char),
    .in_input_at_end (in_input_at_end),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_next_pc     (out_next_pc),
    .out_exec_status (out_exec_status),
    .out_out_valid   (out_out_valid),
    .out_out_char    (out_out_char),
    .out_zero_now    (out_zero_now),
    .out_end_seen    (out_end_seen)
  );

  always #1 clk = ~clk;

  function automatic exec_res_t execute_instr(logic [7:0] op, logic [7:0] arg,
                                              logic [7:0] ch, logic at_end);
    logic [7:0] a;
    logic [7:0] b;
    logic [7:0] r;
    logic       alu;
    logic       take;
    exec_res_t  res;
    a = regs_mirror[arg[3:0]];
    b = regs_mirror[arg[7:4]];
    r = '0;
    alu = 1'b0;
    take = 1'b0;
    res = '0;
    res.status = ST_OK;
    if (halt_mirror) begin
      res.status = ST_HALT;
    end else begin
      case (op)
        OP_INC:  begin r = a + 8'd1; alu = 1'b1; end
        OP_DEC:  begin r = a - 8'd1; alu = 1'b1; end
        OP_MOV:  begin r = b; alu = 1'b1; end
        OP_MOVC: regs_mirror[R0_IDX] = arg;
        OP_LSL:  begin r = a << 1; alu = 1'b1; end
        OP_LSR:  begin r = a >> 1; alu = 1'b1; end
        OP_JMP:  take = 1'b1;
        OP_JZ:   take = zero_mirror;
        OP_JNZ:  take = !zero_mirror;
        OP_JFE:  take = end_mirror;
        OP_RET:  begin halt_mirror = 1'b1; res.status = ST_HALT; end
        OP_ADD:  begin r = a + b; alu = 1'b1; end
        OP_SUB:  begin r = a - b; alu = 1'b1; end
        OP_XOR:  begin r = a ^ b; alu = 1'b1; end
        OP_OR:   begin r = a | b; alu = 1'b1; end
        OP_IN: begin
          if (at_end) end_mirror = 1'b1;
          else regs_mirror[arg[3:0]] = ch;
        end
        OP_OUT: begin res.ovalid = 1'b1; res.ochar = a; end
        default: res.status = ST_ILLEGAL;
      endcase
      if (alu) begin
        regs_mirror[arg[3:0]] = r;
        zero_mirror = (r == 8'd0);
      end
      if (res.status == ST_OK) pc_mirror = take ? pc_mirror + arg : pc_mirror + PC_STEP;
    end
    res.next_pc = pc_mirror;
    res.zero = zero_mirror;
    res.end_f = end_mirror;
    return res;
  endfunction

  function automatic void add_row(logic [7:0] op, logic [7:0] arg, logic [7:0] ch,
                                  logic at_end);
    instr_row_t row;
    row = '0;
    row.op = op;
    row.arg = arg;
    row.ch = ch;
    row.at_end = at_end;
    instr_rows.push_back(row);
  endfunction

  // pins the expected result of the row just added
  function automatic void add_known(logic [7:0] pc, exec_status_t st, logic z, logic e);
    instr_row_t row;
    row = instr_rows.pop_back();
    row.known = 1'b1;
    row.res = '0;
    row.res.next_pc = pc;
    row.res.status = st;
    row.res.zero = z;
    row.res.end_f = e;
    instr_rows.push_back(row);
  endfunction

  task automatic send_instr(instr_row_t row);
    int gap;
    exec_res_t pred;
    gap = calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_op_code      <= row.op;
    in_operand_byte <= row.arg;
    in_input_char   <= row.ch;
    in_input_at_end <= row.at_end;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = execute_instr(row.op, row.arg, row.ch, row.at_end);
    pending_results.push_back(row.known ? row.res : pred);
    if ($urandom_range(0, 49) == 0) calm = !calm;
  endtask

  function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, got_v);
      err_count++;
    end
  endfunction

  always @(posedge clk) begin
    exec_res_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result transaction with nothing expected, actual pc %h status %h",
                 $time, out_next_pc, out_exec_status);
        err_count++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("next_pc", exp_r.next_pc, out_next_pc);
        check_field("exec_status", {6'b0, exp_r.status}, {6'b0, out_exec_status});
        check_field("out_valid", {7'b0, exp_r.ovalid}, {7'b0, out_out_valid});
        check_field("out_char", exp_r.ochar, out_out_char);
        check_field("zero_now", {7'b0, exp_r.zero}, {7'b0, out_zero_now});
        check_field("end_seen", {7'b0, exp_r.end_f}, {7'b0, out_end_seen});
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results outstanding", $time, pending_results.size());
      $display("** small_register_cpu_execute_core: FAILED **");
      $finish;
    end
  end

  // result side: random stall before each transaction
  initial begin
    int gap;
    out_ready <= 1'b0;
    do @(posedge clk); while (!rst_n);
    forever begin
      gap = calm ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    instr_row_t row;
    int pick;
    rst_n           <= 1'b0;
    in_valid        <= 1'b0;
    in_op_code      <= '0;
    in_operand_byte <= '0;
    in_input_char   <= '0;
    in_input_at_end <= 1'b0;
    foreach (regs_mirror[i]) regs_mirror[i] = '0;
    pc_mirror   = '0;
    zero_mirror = 1'b0;
    end_mirror  = 1'b0;
    halt_mirror = 1'b0;

    add_row(OP_INC, 8'h00, 8'h00, 1'b0);     add_known(8'h02, ST_OK, 1'b0, 1'b0);
    add_row(ILL_LOW, 8'h00, 8'h00, 1'b0);    add_known(8'h02, ST_ILLEGAL, 1'b0, 1'b0);
    add_row(ILL_HIGH, 8'hFF, 8'hFF, 1'b1);   add_known(8'h02, ST_ILLEGAL, 1'b0, 1'b0);
    add_row(ILL_FIRST, 8'h55, 8'h00, 1'b0);  add_known(8'h02, ST_ILLEGAL, 1'b0, 1'b0);
    add_row(OP_DEC, 8'h00, 8'h00, 1'b0);     add_known(8'h04, ST_OK, 1'b1, 1'b0);
    add_row(OP_DEC, 8'h01, 8'h00, 1'b0);     // 0 - 1 wraps to ff
    add_row(OP_MOVC, 8'hFF, 8'h00, 1'b0);
    add_row(OP_MOV, 8'h12, 8'h00, 1'b0);
    add_row(OP_LSL, 8'h02, 8'h00, 1'b0);
    add_row(OP_LSR, 8'h02, 8'h00, 1'b0);     // msb must come in as zero
    add_row(OP_ADD, 8'h01, 8'h00, 1'b0);
    add_row(OP_SUB, 8'h11, 8'h00, 1'b0);
    add_row(OP_JZ, 8'h10, 8'h00, 1'b0);
    add_row(OP_JNZ, 8'h80, 8'h00, 1'b0);
    add_row(OP_XOR, 8'h03, 8'h00, 1'b0);
    add_row(OP_JNZ, 8'hFE, 8'h00, 1'b0);     // backward offset
    add_row(OP_OR, 8'h34, 8'h00, 1'b0);
    add_row(OP_OUT, 8'h04, 8'h00, 1'b0);
    add_row(OP_IN, 8'h05, 8'hA5, 1'b0);
    add_row(OP_IN, 8'h06, 8'h5A, 1'b1);      // end of text: register untouched
    add_row(OP_JFE, 8'h80, 8'h00, 1'b0);
    add_row(OP_JMP, 8'h7F, 8'h00, 1'b0);
    add_row(OP_OUT, 8'h05, 8'h00, 1'b0);
    // halt and the ignored transactions after it go last
    add_row(OP_RET, 8'h00, 8'h00, 1'b0);
    add_row(OP_INC, 8'h00, 8'h00, 1'b0);
    add_row(OP_IN, 8'h07, 8'h33, 1'b1);
    add_row(ILL_HIGH, 8'hFF, 8'hFF, 1'b0);

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < HEAD_ROWS; i++) send_instr(instr_rows[i]);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      row = '0;
      pick = $urandom_range(0, 19);
      if (pick == 0) row.op = ILL_LOW;
      else if (pick == 1) row.op = 8'($urandom_range(ILL_FIRST, ILL_HIGH));
      else row.op = run_ops[$urandom_range(0, 15)];
      row.arg = 8'($urandom_range(0, 255));
      row.ch = 8'($urandom_range(0, 255));
      row.at_end = ($urandom_range(0, 7) == 0);
      send_instr(row);
    end

    for (int i = HEAD_ROWS; i < instr_rows.size(); i++) send_instr(instr_rows[i]);
    in_valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("** small_register_cpu_execute_core: PASSED **");
    end else begin
      $display("** small_register_cpu_execute_core: FAILED **");
    end
    $finish;
  end

endmodule
